// ----- rtl/core/tkws_pkg.sv -----
// ----------------------------------------------------------------------------
// tkws_pkg
// Shared constants, types and helpers for the top-k worst cost selector.
// ----------------------------------------------------------------------------
package tkws_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int RESULT_CAP = 32;
    localparam int LIST_CAP   = (LIST_DEPTH < RESULT_CAP) ? LIST_DEPTH : RESULT_CAP;
    localparam int COST_W     = 32;
    localparam int INDEX_W    = 16;
    localparam int RANK_W     = 5;
    localparam int LIMIT_W    = 6;
    localparam int CNT_W      = $clog2(LIST_CAP + 1);
    localparam int SLOT_W     = $clog2(LIST_DEPTH);

    typedef logic [COST_W-1:0]  cost_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [CNT_W-1:0]   count_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_mode_t;

    typedef enum logic {
        ST_SCAN,
        ST_DRAIN
    } sel_state_t;

    // what one cell hands to its neighbors
    typedef struct packed {
        cost_t  cost;
        index_t index;
        logic   keep;
    } cell_link_t;

    // broadcast request to the whole row
    typedef struct packed {
        cell_mode_t mode;
        cost_t      cost;
        index_t     index;
    } cell_ctrl_t;

    localparam count_t LIST_CAP_C = count_t'(LIST_CAP);

    function automatic count_t eff_limit(input logic [LIMIT_W-1:0] lim);
        count_t res;
        if (lim == '0)
            res = count_t'(1);
        else if ({{(32-LIMIT_W){1'b0}}, lim} > 32'(LIST_CAP))
            res = LIST_CAP_C;
        else
            res = count_t'(lim);
        return res;
    endfunction

endpackage

// ----- rtl/core/tkws_cell.sv -----
// ----------------------------------------------------------------------------
// tkws_cell
// One slot of the sorted list: holds, takes the new request, or shifts.
// ----------------------------------------------------------------------------
module tkws_cell
    import tkws_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  cell_link_t prev_link,
    input  cell_link_t next_link,
    output cell_link_t link,
    output logic       not_below
);

    cost_t  cost_reg;
    cost_t  cost_next;
    index_t index_reg;
    index_t index_next;
    logic   keep;

    // ties go to the newer cell, so an equal entry does not keep its slot
    assign keep = occupied && (cost_reg > ctrl.cost);

    // a full list drops a cost that does not beat its tail
    assign not_below = occupied && (cost_reg >= ctrl.cost);

    always_comb
    begin
        cost_next  = cost_reg;
        index_next = index_reg;
        case (ctrl.mode)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_link.keep)
                    begin
                        cost_next  = ctrl.cost;
                        index_next = ctrl.index;
                    end
                    else
                    begin
                        cost_next  = prev_link.cost;
                        index_next = prev_link.index;
                    end
                end
            end
            CELL_SHIFT:
            begin
                cost_next  = next_link.cost;
                index_next = next_link.index;
            end
            default:
            begin
                cost_next  = cost_reg;
                index_next = index_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cost_reg  <= cost_next;
        index_reg <= index_next;
    end

    assign link.cost  = cost_reg;
    assign link.index = index_reg;
    assign link.keep  = keep;

endmodule

// ----- rtl/core/tkws_chain.sv -----
// ----------------------------------------------------------------------------
// tkws_chain
// Row of list cells, highest cost at the head.
// ----------------------------------------------------------------------------
module tkws_chain
    import tkws_pkg::*;
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  count_t                count,
    output cost_t                 head_cost,
    output index_t                head_index,
    output logic [LIST_DEPTH-1:0] not_below
);

    cell_link_t links [LIST_DEPTH];

    localparam cell_link_t HEAD_LINK = '{cost: '0, index: '0, keep: 1'b1};
    localparam cell_link_t TAIL_LINK = '{cost: '0, index: '0, keep: 1'b0};

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        cell_link_t prev_l;
        cell_link_t next_l;
        logic       occ;

        assign occ = (32'(i) < {{(32-CNT_W){1'b0}}, count});

        if (i == 0)
        begin : g_head
            assign prev_l = HEAD_LINK;
        end
        else
        begin : g_mid
            assign prev_l = links[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_tail
            assign next_l = TAIL_LINK;
        end
        else
        begin : g_body
            assign next_l = links[i+1];
        end

        tkws_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occ),
            .prev_link (prev_l),
            .next_link (next_l),
            .link      (links[i]),
            .not_below (not_below[i])
        );
    end

    assign head_cost  = links[0].cost;
    assign head_index = links[0].index;

endmodule

// ----- rtl/core/top_k_worst_cost_selector_top.sv -----
// ----------------------------------------------------------------------------
// top_k_worst_cost_selector_top
// Streaming top-k selection of the highest cell costs of a scan.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one cell cost per request; the
// cells are numbered from zero internally. A request with scan_end set closes
// the scan. Each accepted cost enters the sorted row of cells directly,
// so a scan streams at one cell per clock while in_stall is low.
// The closing request moves the state register to the drain state; the block
// then drains the list through the output register on the output channel
// (out_valid / out_stall), one entry per cycle while out_stall is low, from
// the highest cost down, with final_entry on the last one. While draining,
// in_stall is held high until the last entry has been loaded for output.
// The drain shifts the cell row toward the head, so output stall simply
// freezes the row. The output register lets the next scan start while the
// last entry still waits to be taken.
// cfg_we / cfg_wdata write list_limit (0 acts as 1, above 32 as 32); a lower
// limit truncates the list. Write it only while idle.
// Reset clears the list count, the cell counter and the output valid, and
// sets list_limit to 32. Cell contents need no reset.
// ----------------------------------------------------------------------------
module top_k_worst_cost_selector_top
    import tkws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [COST_W-1:0]   cell_cost,
    input  logic                scan_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_W-1:0]  ranked_index,
    output logic [COST_W-1:0]   ranked_cost,
    output logic [RANK_W-1:0]   rank,
    output logic                final_entry
);

    sel_state_t         state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    count_t             count_reg, count_next;
    index_t             pos_reg, pos_next;
    logic [RANK_W-1:0]  rank_cnt_reg, rank_cnt_next;
    logic               out_valid_reg, out_valid_next;
    index_t             out_index_reg;
    cost_t              out_cost_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    logic               out_final_reg;

    cell_ctrl_t            ctrl;
    cost_t                 head_cost;
    index_t                head_index;
    logic [LIST_DEPTH-1:0] not_below;
    logic [SLOT_W-1:0]     tail_slot;
    logic                  tail_blocks;
    count_t                lim;
    count_t                count_ins;
    logic                  in_acc;
    logic                  out_load;
    logic                  drain_last;

    assign lim        = eff_limit(limit_reg);
    assign in_stall   = (state_reg != ST_SCAN);
    assign in_acc     = in_valid && !in_stall;
    assign out_load   = (state_reg == ST_DRAIN) && (!out_valid_reg || !out_stall);
    assign drain_last = ({1'b0, rank_cnt_reg} + count_t'(1)) >= count_reg;
    assign count_ins  = (count_reg < lim) ? count_reg + count_t'(1) : count_reg;
    assign tail_slot  = SLOT_W'(count_reg - count_t'(1));
    // full list and the new cost does not beat the tail
    assign tail_blocks = (count_reg >= lim) && not_below[tail_slot];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SCAN:
            begin
                if (in_acc && scan_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_load && drain_last)
                    state_next = ST_SCAN;
            end
            default: state_next = ST_SCAN;
        endcase
    end

    // row control and counters
    always_comb
    begin
        ctrl.mode     = CELL_HOLD;
        ctrl.cost     = cell_cost;
        ctrl.index    = pos_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        rank_cnt_next = rank_cnt_reg;
        case (state_reg)
            ST_SCAN:
            begin
                if (in_acc)
                begin
                    if (!tail_blocks)
                        ctrl.mode = CELL_INSERT;
                    count_next    = count_ins;
                    pos_next      = scan_end ? '0 : pos_reg + index_t'(1);
                    rank_cnt_next = '0;
                end
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    ctrl.mode     = CELL_SHIFT;
                    rank_cnt_next = rank_cnt_reg + RANK_W'(1);
                    if (drain_last)
                        count_next = '0;
                end
            end
            default: ctrl.mode = CELL_HOLD;
        endcase
        limit_next = limit_reg;
        if (cfg_we)
        begin
            limit_next = cfg_wdata;
            if (count_next > eff_limit(cfg_wdata))
                count_next = eff_limit(cfg_wdata);
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    tkws_chain u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_reg),
        .head_cost  (head_cost),
        .head_index (head_index),
        .not_below  (not_below)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SCAN;
            limit_reg     <= LIMIT_W'(32);
            count_reg     <= '0;
            pos_reg       <= '0;
            rank_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            rank_cnt_reg  <= rank_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= head_index;
            out_cost_reg  <= head_cost;
            out_rank_reg  <= rank_cnt_reg;
            out_final_reg <= drain_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ranked_index = out_index_reg;
    assign ranked_cost  = out_cost_reg;
    assign rank         = out_rank_reg;
    assign final_entry  = out_final_reg;

    // list never grows past the active limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lim)
        else $error("list count above limit");

    // a closing request always starts a drain with at least one entry
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && scan_end) |=> (state_reg == ST_DRAIN && count_reg != '0
            && rank_cnt_reg == '0))
        else $error("drain did not start correctly");

    // the last drained entry carries final_entry and leaves the list empty
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && drain_last && !cfg_we) |=> (out_final_reg && count_reg == '0
            && state_reg == ST_SCAN && pos_reg == '0))
        else $error("drain end mismatch");

endmodule
